// ===== rtl/sha256_pkg.sv =====
// Package: SHA-256 constants, round functions and shared types.
`default_nettype none
package sha256_pkg;

    localparam int WordWidth  = 32;
    localparam int CountWidth = 61;
    localparam int QueueDepth = 4;
    localparam int BlockBytes = 64;

    typedef logic [31:0] word_t;

    // One classified transaction passed from front to back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } item_t;

    typedef enum logic [2:0] {
        ST_ACCEPT,
        ST_PAD,
        ST_COMPRESS,
        ST_FOLD,
        ST_EMIT
    } back_state_t;

    localparam word_t Iv [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_s0(input word_t a);
        big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    endfunction

    function automatic word_t big_s1(input word_t e);
        big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    endfunction

    function automatic word_t small_s0(input word_t w);
        small_s0 = rotr(w, 7) ^ rotr(w, 18) ^ (w >> 3);
    endfunction

    function automatic word_t small_s1(input word_t w);
        small_s1 = rotr(w, 17) ^ rotr(w, 19) ^ (w >> 10);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sha256_if.sv =====
// Interfaces: input byte channel and digest word channel.
`default_nettype none
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
    modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
    modport sink (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
    modport source (output valid, digest_word, word_index, final_word, input ready);
    modport sink (input valid, digest_word, word_index, final_word, output ready);
endinterface
`default_nettype wire

// ===== rtl/sha256_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module sha256_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(Depth)-1:0] wr_addr,
    input  wire logic [Width-1:0]         wr_data,
    input  wire logic [$clog2(Depth)-1:0] rd_addr,
    output logic      [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    // Write and read one entry each cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/sha256_front.sv =====
// Front end: accepts input transactions, drops idle ones, queues the rest.
`default_nettype none
module sha256_front #(
    parameter int Depth = sha256_pkg::QueueDepth
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    sha256_in_if.sink                 in_ch,
    output logic                      q_valid,
    output sha256_pkg::item_t         q_item,
    input  wire logic                 q_pop
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    sha256_pkg::item_t slot_reg [Depth];
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next, wr_ptr_reg, wr_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic          push;

    assign in_ch.ready = (count_reg != (AW+1)'(Depth));
    // Idle transactions carry no work: drop them here
    assign push = in_ch.valid && in_ch.ready && (in_ch.byte_valid || in_ch.end_of_message);
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (AW+1)'(push) - (AW+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store queued transaction
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{in_ch.data_byte, in_ch.byte_valid, in_ch.end_of_message};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sha256_back.sv =====
// Back end: block gathering, padding, 64-round compression and digest output.
`default_nettype none
module sha256_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  sha256_pkg::item_t  q_item,
    output logic               q_pop,
    sha256_out_if.source       out_ch
);

    sha256_pkg::back_state_t state_reg, state_next;

    logic [60:0] count_reg, count_next;
    logic [63:0] bits_reg;
    logic        fin_reg;       // message finishing: padding in progress
    logic        emit_after_reg;
    logic        pad_mark_reg;  // 0x80 already written
    logic        last_blk_reg;  // current padding block carries the bit length
    logic [6:0]  rnd_reg;       // 0..65 round counter, counted after the load phase
    logic [2:0]  widx_reg;

    sha256_pkg::word_t h_reg [8];
    sha256_pkg::word_t v_reg [8];
    sha256_pkg::word_t w_reg [16];

    // Block store RAM: byte written in, word assembled a byte per cycle on load
    logic       wr_en;
    logic [5:0] wr_addr, rd_addr;
    logic [7:0] wr_data, rd_data;

    sha256_ram #(.Width(8), .Depth(sha256_pkg::BlockBytes)) u_store (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    logic [5:0] pos;
    logic [7:0] pad_data;
    logic [6:0] byte_ctr_reg;   // load: 0..65 byte read counter
    sha256_pkg::word_t w_new, t1, t2, wcur;

    assign pos = count_reg[5:0];

    // Pick the padding byte for this position
    always_comb
    begin
        if (!pad_mark_reg)
        begin
            pad_data = sha256_pkg::PadByte;
        end
        else if (last_blk_reg && pos >= sha256_pkg::LenPos)
        begin
            pad_data = bits_reg[8*(7 - (pos - sha256_pkg::LenPos)) +: 8];
        end
        else
        begin
            pad_data = 8'h00;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha256_pkg::ST_ACCEPT:
            begin
                if (q_valid)
                begin
                    if (q_item.byte_valid && pos == 6'd63)
                    begin
                        state_next = sha256_pkg::ST_COMPRESS;
                    end
                    else if (q_item.end_of_message)
                    begin
                        state_next = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_PAD:
            begin
                if (pos == 6'd63)
                begin
                    state_next = sha256_pkg::ST_COMPRESS;
                end
            end
            sha256_pkg::ST_COMPRESS:
            begin
                if (rnd_reg == 7'd64 + 7'd1 && byte_ctr_reg == 7'd65)
                begin
                    state_next = sha256_pkg::ST_FOLD;
                end
            end
            sha256_pkg::ST_FOLD:
            begin
                if (emit_after_reg)
                begin
                    state_next = sha256_pkg::ST_EMIT;
                end
                else if (fin_reg)
                begin
                    state_next = sha256_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha256_pkg::ST_ACCEPT;
                end
            end
            sha256_pkg::ST_EMIT:
            begin
                if (out_ch.ready && widx_reg == 3'd7)
                begin
                    state_next = sha256_pkg::ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = sha256_pkg::ST_ACCEPT;
            end
        endcase
    end

    // Outputs of the state machine
    always_comb
    begin
        q_pop   = 1'b0;
        wr_en   = 1'b0;
        wr_data = q_item.data_byte;
        unique case (state_reg)
            sha256_pkg::ST_ACCEPT:
            begin
                q_pop = q_valid;
                wr_en = q_valid && q_item.byte_valid;
            end
            sha256_pkg::ST_PAD:
            begin
                wr_en   = 1'b1;
                wr_data = pad_data;
            end
            default:
            begin
            end
        endcase
    end

    assign wr_addr = pos;
    assign rd_addr = byte_ctr_reg[5:0];

    assign out_ch.valid       = (state_reg == sha256_pkg::ST_EMIT);
    assign out_ch.digest_word = h_reg[widx_reg];
    assign out_ch.word_index  = widx_reg;
    assign out_ch.final_word  = (widx_reg == 3'd7);

    // Round datapath: schedule word and the two temporaries
    always_comb
    begin
        w_new = sha256_pkg::small_s1(w_reg[14]) + w_reg[9] +
                sha256_pkg::small_s0(w_reg[1]) + w_reg[0];
        wcur  = (rnd_reg < 7'd16) ? w_reg[rnd_reg[3:0]] : w_new;
        t1 = v_reg[7] + sha256_pkg::big_s1(v_reg[4]) +
             ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) +
             sha256_pkg::RoundK[rnd_reg[5:0]] + wcur;
        t2 = sha256_pkg::big_s0(v_reg[0]) +
             ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // Byte count: advance on each stored byte, clear after the last digest word
    always_comb
    begin
        count_next = count_reg;
        if (state_reg == sha256_pkg::ST_EMIT && out_ch.ready && widx_reg == 3'd7)
        begin
            count_next = '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + 61'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sha256_pkg::ST_ACCEPT;
            count_reg      <= '0;
            bits_reg       <= '0;
            fin_reg        <= 1'b0;
            emit_after_reg <= 1'b0;
            pad_mark_reg   <= 1'b0;
            last_blk_reg   <= 1'b0;
            rnd_reg        <= '0;
            byte_ctr_reg   <= '0;
            widx_reg       <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256_pkg::Iv[i];
                v_reg[i] <= '0;
            end
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            // Start of finish: latch bit length from count after this byte
            if (state_reg == sha256_pkg::ST_ACCEPT && q_valid && q_item.end_of_message)
            begin
                fin_reg      <= 1'b1;
                pad_mark_reg <= 1'b0;
                last_blk_reg <= 1'b0;
                bits_reg     <= {count_next, 3'b000};
            end
            // Padding: the length goes into the block where 0x80 left room for it
            if (state_reg == sha256_pkg::ST_PAD)
            begin
                pad_mark_reg <= 1'b1;
                if (pos == 6'd63)
                begin
                    if (last_blk_reg)
                    begin
                        fin_reg        <= 1'b0;
                        emit_after_reg <= 1'b1;
                    end
                    else
                    begin
                        last_blk_reg <= 1'b1;
                    end
                end
                else if (!pad_mark_reg && pos < sha256_pkg::LenPos)
                begin
                    last_blk_reg <= 1'b1;
                end
            end
            if (state_next == sha256_pkg::ST_COMPRESS && state_reg != sha256_pkg::ST_COMPRESS)
            begin
                byte_ctr_reg <= '0;
                rnd_reg      <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
            if (state_reg == sha256_pkg::ST_COMPRESS)
            begin
                // Load phase: shift bytes into the window, one per cycle
                if (byte_ctr_reg != 7'd65)
                begin
                    byte_ctr_reg <= byte_ctr_reg + 7'd1;
                    if (byte_ctr_reg != 7'd0)
                    begin
                        w_reg[15] <= {w_reg[15][23:0], rd_data};
                        // Move the finished word down as the next word starts
                        if (byte_ctr_reg[1:0] == 2'b01 && byte_ctr_reg != 7'd1)
                        begin
                            for (int i = 0; i < 15; i++)
                            begin
                                w_reg[i] <= w_reg[i+1];
                            end
                        end
                    end
                end
                else if (rnd_reg != 7'd65)
                begin
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg != 7'd64)
                    begin
                        if (rnd_reg >= 7'd16)
                        begin
                            for (int i = 0; i < 15; i++)
                            begin
                                w_reg[i] <= w_reg[i+1];
                            end
                            w_reg[15] <= w_new;
                        end
                        v_reg[7] <= v_reg[6];
                        v_reg[6] <= v_reg[5];
                        v_reg[5] <= v_reg[4];
                        v_reg[4] <= v_reg[3] + t1;
                        v_reg[3] <= v_reg[2];
                        v_reg[2] <= v_reg[1];
                        v_reg[1] <= v_reg[0];
                        v_reg[0] <= t1 + t2;
                    end
                end
            end
            if (state_reg == sha256_pkg::ST_FOLD)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
                widx_reg <= '0;
            end
            if (state_reg == sha256_pkg::ST_EMIT && out_ch.ready)
            begin
                widx_reg <= widx_reg + 3'd1;
                if (widx_reg == 3'd7)
                begin
                    emit_after_reg <= 1'b0;
                    fin_reg        <= 1'b0;
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= sha256_pkg::Iv[i];
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sha256_stream_hasher_core.sv =====
// Top level: SHA-256 byte stream hasher, front queue plus compression back end.
// Usage:
//   in_ch carries one byte per transaction with byte_valid and end_of_message.
//   Transactions with neither flag set are dropped. A transaction with
//   end_of_message pads the message, appends the 64-bit bit length and
//   produces eight digest transactions on out_ch, word 0 first, with
//   final_word set on word 7.
//   Throughput: one queued byte per cycle into the block store while the
//   back end is accepting; each full 64-byte block then holds the back end
//   for the byte loads into the schedule window, the round phase for the 64
//   rounds and one fold, so the sustained rate is set by the single round
//   unit and the one-read byte store.
//   From the back end taking the end_of_message transaction to word 0, the
//   back end runs the padding and one compression, or two compressions when
//   the 0x80 byte and the length need a second block.
//   A four-entry queue between front and back keeps in_ch ready while the
//   back end compresses, until it fills.
//   Reset clears the queue, the byte count and restores the initial hash.
//   When out_ch stalls the current word holds and no further transactions
//   are taken from the queue.
`default_nettype none
module sha256_stream_hasher_core #(
    parameter int QueueDepth = sha256_pkg::QueueDepth
) (
    input wire logic     clk,
    input wire logic     rst_n,
    sha256_in_if.sink    in_ch,
    sha256_out_if.source out_ch
);

    logic              q_valid, q_pop;
    sha256_pkg::item_t q_item;

    sha256_front #(.Depth(QueueDepth)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    sha256_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .q_pop(q_pop), .out_ch(out_ch)
    );

    // Back end never pops from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");

    // Word index advances after each accepted digest transaction before the final word
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && !out_ch.final_word) |=>
        (out_ch.word_index == $past(out_ch.word_index) + 3'd1))
        else $error("digest word order broken");

    // Final word flag marks index seven only
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.final_word == (out_ch.word_index == 3'd7)))
        else $error("final word flag mismatch");

endmodule
`default_nettype wire
